@@ src/sbb_pkg.sv @@
// ----------------------------------------------------------------------------
// sbb_pkg: shared definitions for the spectrum band ballistics block
// Field widths, register codes, reset values and small arithmetic helpers.
// ----------------------------------------------------------------------------
package sbb_pkg;

	localparam int BAND_W     = 8;
	localparam int POWER_W    = 32;
	localparam int LEVEL_W    = 16;
	localparam int COEF_W     = 17;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;
	localparam int BANDS_DEF  = 256;

	localparam logic [COEF_W-1:0]  COEF_ONE     = 17'h10000;
	localparam logic [31:0]        DB_SCALE     = 32'd197283;
	localparam logic [31:0]        DB_ROUND     = 32'd32768;
	localparam logic [13:0]        LOG_FULL     = 14'd8192;
	localparam logic [15:0]        FLOOR_RESET  = 16'hB000;
	localparam logic [15:0]        GAIN_RESET   = 16'd819;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_AVERAGE_COEF    = 3'd0,
		REG_ATTACK_COEF     = 3'd1,
		REG_RELEASE_COEF    = 3'd2,
		REG_PEAK_HOLD_ON    = 3'd3,
		REG_PEAK_DECAY_STEP = 3'd4,
		REG_DB_FLOOR        = 3'd5,
		REG_NORM_GAIN       = 3'd6
	} cfg_reg_t;

	// Per-band state word held in the band memory.
	typedef struct packed {
		logic [POWER_W-1:0] avg;
		logic [LEVEL_W-1:0] disp;
		logic [LEVEL_W-1:0] peak;
	} entry_t;

	// Weights above one act as one.
	function automatic logic [COEF_W-1:0] sat_coef(input logic [COEF_W-1:0] c);
		return (c > COEF_ONE) ? COEF_ONE : c;
	endfunction

	// log2(1 + k/16) in Q.8, rounded.
	function automatic logic [8:0] log_tab(input logic [4:0] k);
		logic [8:0] v;
		case (k)
			5'd0:    v = 9'd0;
			5'd1:    v = 9'd22;
			5'd2:    v = 9'd44;
			5'd3:    v = 9'd63;
			5'd4:    v = 9'd82;
			5'd5:    v = 9'd100;
			5'd6:    v = 9'd118;
			5'd7:    v = 9'd134;
			5'd8:    v = 9'd150;
			5'd9:    v = 9'd165;
			5'd10:   v = 9'd179;
			5'd11:   v = 9'd193;
			5'd12:   v = 9'd207;
			5'd13:   v = 9'd220;
			5'd14:   v = 9'd232;
			5'd15:   v = 9'd244;
			5'd16:   v = 9'd256;
			default: v = 9'd0;
		endcase
		return v;
	endfunction

	// Position of the highest set bit; zero when no bit is set.
	function automatic logic [4:0] lead_one(input logic [POWER_W-1:0] x);
		logic [4:0] e;
		e = 5'd0;
		for (int i = 0; i < POWER_W; i++) begin
			if (x[i]) begin
				e = 5'(i);
			end
		end
		return e;
	endfunction

endpackage

@@ src/sbb_in_if.sv @@
// ----------------------------------------------------------------------------
// sbb_in_if: band power channel
// Valid/ready channel carrying one band index and its linear power.
// ----------------------------------------------------------------------------
interface sbb_in_if;
	import sbb_pkg::*;

	logic               valid;
	logic               ready;
	logic [BAND_W-1:0]  band_index;
	logic [POWER_W-1:0] band_power;

	modport source (output valid, output band_index, output band_power, input ready);
	modport sink (input valid, input band_index, input band_power, output ready);
endinterface

@@ src/sbb_out_if.sv @@
// ----------------------------------------------------------------------------
// sbb_out_if: display result channel
// Valid/ready channel carrying a band index, its display level and its peak.
// ----------------------------------------------------------------------------
interface sbb_out_if;
	import sbb_pkg::*;

	logic               valid;
	logic               ready;
	logic [BAND_W-1:0]  out_band;
	logic [LEVEL_W-1:0] display_level;
	logic [LEVEL_W-1:0] peak_level;

	modport source (output valid, output out_band, output display_level,
		output peak_level, input ready);
	modport sink (input valid, input out_band, input display_level,
		input peak_level, output ready);
endinterface

@@ src/spectrum_band_ballistics.sv @@
// ----------------------------------------------------------------------------
// spectrum_band_ballistics: per-band spectrum display ballistics
// Running power average, dB conversion, level mapping, attack/release
// smoothing and decaying peak hold, with all band state in one memory.
// ----------------------------------------------------------------------------
// Usage: each transaction on the band channel carries a band index and its
// linear power in Q0.32. Each one yields exactly one transaction on the result
// channel, in order, with the band, its smoothed display level and its peak.
// A new band is taken every cycle unless the clear pass, a same-band wait or
// a result stall holds it. Each result passes through the arithmetic pipeline
// between the memory read and the write-back, then the result register. A
// band that matches one still in the pipeline waits until that one has
// written its state back; distinct bands stream at one per cycle while
// nothing else holds them. Bands at or above BANDS touch no state and return
// zeros. After reset the block clears the band memory, one entry per cycle,
// and accepts no band meanwhile; configuration writes are
// taken at any time. When the result receiver stalls, the whole pipeline
// holds and the band channel stops accepting; the result register keeps its
// transaction until it is taken.
// ----------------------------------------------------------------------------
module spectrum_band_ballistics #(
	parameter int BANDS = sbb_pkg::BANDS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	sbb_in_if.sink                          band,
	sbb_out_if.source                       result,
	input  logic                            cfg_write,
	input  logic [sbb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sbb_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import sbb_pkg::*;

	localparam int AW = (BANDS > 1) ? $clog2(BANDS) : 1;

	// Control and state carried down the pipeline with each transaction.
	typedef struct packed {
		logic              valid;
		logic              inr;
		logic [BAND_W-1:0] band;
		entry_t            st;
	} ctl_t;

	// ------------------------------------------------------------------
	// Configuration registers.
	// ------------------------------------------------------------------
	logic [COEF_W-1:0]  avg_coef_q;
	logic [COEF_W-1:0]  atk_coef_q;
	logic [COEF_W-1:0]  rel_coef_q;
	logic               hold_on_q;
	logic [LEVEL_W-1:0] decay_q;
	logic [LEVEL_W-1:0] floor_q;
	logic [LEVEL_W-1:0] gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_coef_q <= COEF_ONE;
			atk_coef_q <= COEF_ONE;
			rel_coef_q <= COEF_ONE;
			hold_on_q  <= 1'b0;
			decay_q    <= '0;
			floor_q    <= FLOOR_RESET;
			gain_q     <= GAIN_RESET;
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				REG_AVERAGE_COEF:    avg_coef_q <= cfg_data;
				REG_ATTACK_COEF:     atk_coef_q <= cfg_data;
				REG_RELEASE_COEF:    rel_coef_q <= cfg_data;
				REG_PEAK_HOLD_ON:    hold_on_q  <= cfg_data[0];
				REG_PEAK_DECAY_STEP: decay_q    <= cfg_data[LEVEL_W-1:0];
				REG_DB_FLOOR:        floor_q    <= cfg_data[LEVEL_W-1:0];
				REG_NORM_GAIN:       gain_q     <= cfg_data[LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Pipeline control registers, one per stage.
	// ------------------------------------------------------------------
	ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6, ctl_s7;
	ctl_t ctl_s8, ctl_s9, ctl_s10, ctl_s11, ctl_s12, ctl_s13;

	logic               clr_q;
	logic [AW-1:0]      clr_addr_q;
	logic               out_valid_q;
	logic [BAND_W-1:0]  out_band_q;
	logic [LEVEL_W-1:0] out_disp_q;
	logic [LEVEL_W-1:0] out_peak_q;

	logic adv;
	logic in_inr;
	logic hazard;
	logic accept;

	// A band still in flight has not yet written its state back; the memory
	// read for a repeat of it must wait. The last stage writes at the same
	// edge as a new read would happen, so it counts too.
	function automatic logic hit(input ctl_t c, input logic [BAND_W-1:0] b);
		return c.valid && c.inr && (c.band == b);
	endfunction

	assign adv    = !out_valid_q || result.ready;
	assign in_inr = (32'(band.band_index) < 32'(BANDS));
	assign hazard = in_inr && (hit(ctl_s1, band.band_index) ||
		hit(ctl_s2, band.band_index) || hit(ctl_s3, band.band_index) ||
		hit(ctl_s4, band.band_index) || hit(ctl_s5, band.band_index) ||
		hit(ctl_s6, band.band_index) || hit(ctl_s7, band.band_index) ||
		hit(ctl_s8, band.band_index) || hit(ctl_s9, band.band_index) ||
		hit(ctl_s10, band.band_index) || hit(ctl_s11, band.band_index) ||
		hit(ctl_s12, band.band_index) || hit(ctl_s13, band.band_index));

	assign band.ready = adv && !clr_q && !hazard;
	assign accept     = band.valid && band.ready;

	// ------------------------------------------------------------------
	// Band state memory: read at acceptance, written from the last stage.
	// ------------------------------------------------------------------
	entry_t             band_mem_q [BANDS];
	entry_t             mem_rd_s1;
	logic               mem_we;
	logic [AW-1:0]      mem_wa;
	entry_t             mem_wd;
	entry_t             new_st;
	logic [LEVEL_W-1:0] peak_new;

	assign mem_we = clr_q || (adv && ctl_s13.valid && ctl_s13.inr);
	assign mem_wa = clr_q ? clr_addr_q : AW'(ctl_s13.band);
	assign mem_wd = clr_q ? entry_t'('0) : new_st;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			band_mem_q[mem_wa] <= mem_wd;
		end
		if (adv) begin
			mem_rd_s1 <= band_mem_q[AW'(band.band_index)];
		end
	end

	// Clearing pass after reset, one entry per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == AW'(BANDS - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Arithmetic datapath registers.
	// ------------------------------------------------------------------
	logic [POWER_W-1:0]   pow_s1;
	logic signed [32:0]   adiff_s2;
	logic signed [50:0]   aprod_s3;
	logic [4:0]           e_s5;
	logic [4:0]           e_s6;
	logic [8:0]           lo_s6;
	logic [4:0]           dl_s6;
	logic [7:0]           t_s6;
	logic [12:0]          lg_s7;
	logic [14:0]          dbmag_s8;
	logic signed [17:0]   d_s9;
	logic [LEVEL_W-1:0]   level_s10;
	logic signed [16:0]   ddiff_s11;
	logic [COEF_W-1:0]    csel_s11;
	logic signed [34:0]   dprod_s12;

	// Combinational pieces between stages.
	logic signed [34:0]   asum;
	logic [POWER_W-1:0]   avg_new;
	logic [POWER_W-1:0]   lx;
	logic [POWER_W-1:0]   mant;
	logic [12:0]          frac;
	logic [31:0]          dbprod;
	logic [31:0]          lprod;
	logic [LEVEL_W-1:0]   level_new;
	logic                 rise;
	logic signed [18:0]   dsum;
	logic [LEVEL_W-1:0]   disp_new;

	always_comb begin
		// Running average: avg + floor(c * (p - avg) / 65536), clamped.
		asum = $signed({3'b000, ctl_s3.st.avg}) + $signed(aprod_s3[50:16]);
		if (asum[34]) begin
			avg_new = '0;
		end else if (asum[33:32] != 2'b00) begin
			avg_new = '1;
		end else begin
			avg_new = asum[31:0];
		end

		// Normalize the average so its leading one sits at bit 31.
		lx   = (ctl_s5.st.avg == '0) ? 32'd1 : ctl_s5.st.avg;
		mant = lx << (5'd31 - e_s5);

		frac = 13'(dl_s6) * 13'(t_s6);

		dbprod = 32'(LOG_FULL - {1'b0, lg_s7}) * DB_SCALE + DB_ROUND;

		// Level mapping, zero at or below the floor, saturated to full scale.
		lprod = 32'(d_s9[15:0]) * 32'(gain_q);
		if (d_s9[17] || d_s9 == '0) begin
			level_new = '0;
		end else if (lprod[31:24] != 8'h00) begin
			level_new = '1;
		end else begin
			level_new = lprod[23:8];
		end

		rise = level_s10 > ctl_s10.st.disp;

		dsum = $signed({3'b000, ctl_s12.st.disp}) + $signed(dprod_s12[34:16]);
		if (dsum[18]) begin
			disp_new = '0;
		end else if (dsum[17:16] != 2'b00) begin
			disp_new = '1;
		end else begin
			disp_new = dsum[15:0];
		end

		// Peak follows display up, decays linearly; zero with hold off.
		if (!hold_on_q) begin
			peak_new = '0;
		end else if (ctl_s13.st.disp > ctl_s13.st.peak) begin
			peak_new = ctl_s13.st.disp;
		end else if (ctl_s13.st.peak > decay_q) begin
			peak_new = ctl_s13.st.peak - decay_q;
		end else begin
			peak_new = '0;
		end

		new_st      = ctl_s13.st;
		new_st.peak = peak_new;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pow_s1    <= band.band_power;
			adiff_s2  <= $signed({1'b0, pow_s1}) - $signed({1'b0, mem_rd_s1.avg});
			aprod_s3  <= $signed({1'b0, sat_coef(avg_coef_q)}) * adiff_s2;
			e_s5      <= lead_one(ctl_s4.st.avg);
			e_s6      <= e_s5;
			lo_s6     <= log_tab({1'b0, mant[30:27]});
			dl_s6     <= 5'(log_tab({1'b0, mant[30:27]} + 5'd1) - log_tab({1'b0, mant[30:27]}));
			t_s6      <= mant[26:19];
			lg_s7     <= {e_s6, 8'h00} + 13'(lo_s6) + (frac >> 8);
			dbmag_s8  <= dbprod[30:16];
			d_s9      <= $signed(18'd0) - $signed({3'b000, dbmag_s8})
				- $signed({{2{floor_q[15]}}, floor_q});
			level_s10 <= level_new;
			ddiff_s11 <= $signed({1'b0, level_s10}) - $signed({1'b0, ctl_s10.st.disp});
			csel_s11  <= sat_coef(rise ? atk_coef_q : rel_coef_q);
			dprod_s12 <= $signed({1'b0, csel_s11}) * ddiff_s11;

			out_band_q <= ctl_s13.band;
			out_disp_q <= ctl_s13.inr ? ctl_s13.st.disp : '0;
			out_peak_q <= ctl_s13.inr ? peak_new : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1      <= '0;
			ctl_s2      <= '0;
			ctl_s3      <= '0;
			ctl_s4      <= '0;
			ctl_s5      <= '0;
			ctl_s6      <= '0;
			ctl_s7      <= '0;
			ctl_s8      <= '0;
			ctl_s9      <= '0;
			ctl_s10     <= '0;
			ctl_s11     <= '0;
			ctl_s12     <= '0;
			ctl_s13     <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			ctl_s1       <= {accept, in_inr, band.band_index, entry_t'('0)};
			// The state read for this band joins its transaction here.
			ctl_s2       <= {ctl_s1.valid, ctl_s1.inr, ctl_s1.band, mem_rd_s1};
			ctl_s3       <= ctl_s2;
			ctl_s4       <= {ctl_s3.valid, ctl_s3.inr, ctl_s3.band, avg_new,
				ctl_s3.st.disp, ctl_s3.st.peak};
			ctl_s5       <= ctl_s4;
			ctl_s6       <= ctl_s5;
			ctl_s7       <= ctl_s6;
			ctl_s8       <= ctl_s7;
			ctl_s9       <= ctl_s8;
			ctl_s10      <= ctl_s9;
			ctl_s11      <= ctl_s10;
			ctl_s12      <= ctl_s11;
			ctl_s13      <= {ctl_s12.valid, ctl_s12.inr, ctl_s12.band, ctl_s12.st.avg,
				disp_new, ctl_s12.st.peak};
			out_valid_q  <= ctl_s13.valid;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.out_band      = out_band_q;
	assign result.display_level = out_disp_q;
	assign result.peak_level    = out_peak_q;

endmodule

@@ test/sbb_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbb_checker: result predictor and scoreboard for spectrum band ballistics
// Watches the band and result channels and the register write port, predicts
// each band's display level and peak, and compares them in order.
// ----------------------------------------------------------------------------
module sbb_checker #(
	parameter int BANDS = sbb_pkg::BANDS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	sbb_in_if                              band_mon,
	sbb_out_if                             result_mon,
	input  logic                           cfg_write,
	input  logic [sbb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sbb_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             mismatches,
	output int                             owed
);
	import sbb_pkg::*;

	typedef struct packed {
		logic [BAND_W-1:0]  band;
		logic [LEVEL_W-1:0] disp;
		logic [LEVEL_W-1:0] peak;
	} band_view_t;

	// Fractional part of log2(1 + k/16), scaled by 256.
	localparam int unsigned LOG2_FRAC [17] = '{
		0, 22, 44, 63, 82, 100, 118, 134, 150, 165, 179, 193, 207, 220, 232, 244, 256
	};

	logic [COEF_W-1:0]   w_average;
	logic [COEF_W-1:0]   w_attack;
	logic [COEF_W-1:0]   w_release;
	logic                hold_enable;
	logic [LEVEL_W-1:0]  decay_step;
	logic signed [15:0]  floor_db;
	logic [15:0]         gain;

	logic [POWER_W-1:0]  band_averages [BANDS];
	logic [LEVEL_W-1:0]  band_displays [BANDS];
	logic [LEVEL_W-1:0]  band_peaks    [BANDS];

	band_view_t          owed_views [$];

	// Moves acc toward target by coef/65536, rounding toward minus infinity.
	function automatic longint weigh(input longint acc, input longint target,
		input logic [COEF_W-1:0] coef);
		longint c;
		c = (coef > COEF_ONE) ? 64'sd65536 : longint'(coef);
		return acc + ((c * (target - acc)) >>> 16);
	endfunction

	// log2 in Q5.8 by table lookup with linear interpolation.
	function automatic int unsigned log2_q5_8(input logic [31:0] x);
		logic [31:0] m;
		int unsigned e, i, t, lo, hi;
		if (x == 0) begin
			x = 1;
		end
		e = 0;
		for (int k = 0; k < 32; k++) begin
			if (x[k]) begin
				e = k;
			end
		end
		m  = x << (31 - e);
		i  = 32'(m[30:27]);
		t  = 32'(m[26:19]);
		lo = LOG2_FRAC[i];
		hi = LOG2_FRAC[i + 1];
		return e * 256 + lo + (((hi - lo) * t) >> 8);
	endfunction

	// Updates the band's state for one power value and returns its display view.
	function automatic band_view_t predict_display(input logic [BAND_W-1:0] b,
		input logic [POWER_W-1:0] p);
		band_view_t  v;
		longint      avg, db, diff, lvl, disp, pk;
		int unsigned lg;
		v.band = b;
		v.disp = '0;
		v.peak = '0;
		if (b >= BANDS) begin
			return v;
		end
		avg = weigh(longint'(band_averages[b]), longint'(p), w_average);
		if (avg < 0) begin
			avg = 0;
		end
		if (avg > 64'sh0FFFF_FFFF) begin
			avg = 64'sh0FFFF_FFFF;
		end
		band_averages[b] = avg[31:0];

		lg = log2_q5_8(avg[31:0]);
		db = -(((longint'(8192 - lg)) * 197283 + 32768) >>> 16);

		diff = db - longint'(floor_db);
		if (diff <= 0) begin
			lvl = 0;
		end else begin
			lvl = (diff * longint'(gain)) >>> 8;
			if (lvl > 65535) begin
				lvl = 65535;
			end
		end

		disp = weigh(longint'(band_displays[b]), lvl,
			(lvl > longint'(band_displays[b])) ? w_attack : w_release);
		if (disp < 0) begin
			disp = 0;
		end
		if (disp > 65535) begin
			disp = 65535;
		end
		band_displays[b] = disp[15:0];

		pk = longint'(band_peaks[b]);
		if (!hold_enable) begin
			pk = 0;
		end else if (disp > pk) begin
			pk = disp;
		end else begin
			pk = (pk > longint'(decay_step)) ? pk - longint'(decay_step) : 0;
		end
		band_peaks[b] = pk[15:0];

		v.disp = disp[15:0];
		v.peak = pk[15:0];
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		band_view_t seen, want;
		if (!arst_n) begin
			w_average   = COEF_ONE;
			w_attack    = COEF_ONE;
			w_release   = COEF_ONE;
			hold_enable = 1'b0;
			decay_step  = '0;
			floor_db    = FLOOR_RESET;
			gain        = GAIN_RESET;
			for (int k = 0; k < BANDS; k++) begin
				band_averages[k] = '0;
				band_displays[k] = '0;
				band_peaks[k]    = '0;
			end
			owed_views.delete();
			mismatches = 0;
			owed       = 0;
		end else begin
			if (cfg_write) begin
				case (cfg_reg_t'(cfg_index))
					REG_AVERAGE_COEF:    w_average   = cfg_data[COEF_W-1:0];
					REG_ATTACK_COEF:     w_attack    = cfg_data[COEF_W-1:0];
					REG_RELEASE_COEF:    w_release   = cfg_data[COEF_W-1:0];
					REG_PEAK_HOLD_ON:    hold_enable = cfg_data[0];
					REG_PEAK_DECAY_STEP: decay_step  = cfg_data[15:0];
					REG_DB_FLOOR:        floor_db    = cfg_data[15:0];
					REG_NORM_GAIN:       gain        = cfg_data[15:0];
					default: ;
				endcase
			end

			if (band_mon.valid && band_mon.ready) begin
				owed_views.push_back(predict_display(band_mon.band_index,
					band_mon.band_power));
			end

			if (result_mon.valid && result_mon.ready) begin
				seen.band = result_mon.out_band;
				seen.disp = result_mon.display_level;
				seen.peak = result_mon.peak_level;
				if (owed_views.size() == 0) begin
					$error("unexpected result transaction: band %0d display %0d peak %0d",
						seen.band, seen.disp, seen.peak);
					mismatches++;
				end else begin
					want = owed_views.pop_front();
					if (seen.band !== want.band) begin
						$error("out_band: expected %0d, got %0d", want.band, seen.band);
						mismatches++;
					end
					if (seen.disp !== want.disp) begin
						$error("display_level: expected %0d, got %0d (band %0d)",
							want.disp, seen.disp, want.band);
						mismatches++;
					end
					if (seen.peak !== want.peak) begin
						$error("peak_level: expected %0d, got %0d (band %0d)",
							want.peak, seen.peak, want.band);
						mismatches++;
					end
				end
			end

			owed = owed_views.size();
		end
	end

endmodule

@@ test/tb_spectrum_band_ballistics.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_spectrum_band_ballistics: regression for the spectrum band ballistics
// Drives band power transactions and register writes with random idling on
// both channels; the checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module tb_spectrum_band_ballistics;
	import sbb_pkg::*;

	localparam int BANDS = BANDS_DEF;

	// Register index with no register behind it; the block must ignore it.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

	// Cycles to let pass after the last owed result before touching the
	// registers or ending the run. The pipeline is 14 deep.
	localparam int TAIL_CYCLES = 20;

	// Length of the one long hold-off on the result side.
	localparam int LONG_HOLD_CYCLES = 80;

	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_ITEMS   = 85;

	// The limit is several times the length of the slowest correct run (clear
	// pass, same-band waits, maximum idling on both sides, the long hold-off
	// and drains).
	localparam longint RUN_LIMIT_NS = 64'd3_000_000;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_write;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int mismatch_count;
	int results_owed;

	// Idling controls shared by the sender and the receiver process.
	bit tx_steady;
	bit rx_steady;
	bit want_long_hold;

	sbb_in_if  band_ch ();
	sbb_out_if result_ch ();

	spectrum_band_ballistics #(
		.BANDS(BANDS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.band     (band_ch),
		.result   (result_ch),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	sbb_checker #(
		.BANDS(BANDS)
	) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.band_mon  (band_ch),
		.result_mon(result_ch),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.mismatches(mismatch_count),
		.owed      (results_owed)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Hard stop in case the block hangs somewhere.
	initial begin
		#(RUN_LIMIT_NS);
		$display("[FAIL] regression broken");
		$finish;
	end

	// Result receiver. For every transaction it draws a stall, holds ready low
	// that long and then waits with ready high until a result is taken. Once
	// the stimulus asks for it, it holds off for a long stretch instead, so
	// that the pipeline backs up and the band channel stops accepting.
	initial begin
		int stall;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (want_long_hold) begin
				want_long_hold = 1'b0;
				stall = LONG_HOLD_CYCLES;
			end else begin
				stall = rx_steady ? 0 : $urandom_range(0, 4);
			end
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			result_ch.ready <= 1'b1;
			@(posedge clk);
			while (!result_ch.valid) @(posedge clk);
			@(negedge clk);
		end
	end

	// All stimulus tasks start and end at a falling edge. Each one makes at
	// most one assignment to a signal at that edge, so a valid that stays
	// high from one transaction to the next is never lowered and raised
	// within the same time step.

	// Offers one band transaction after a random gap and waits for it to be
	// taken. The first band transactions after reset also wait out the
	// block's memory clear pass here.
	task automatic send_band(input logic [BAND_W-1:0] b, input logic [POWER_W-1:0] p);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			band_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		band_ch.valid      <= 1'b1;
		band_ch.band_index <= b;
		band_ch.band_power <= p;
		@(posedge clk);
		while (!band_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	// Stops offering bands until every owed result has come back, then lets
	// the pipeline settle.
	task automatic drain();
		band_ch.valid <= 1'b0;
		while (results_owed != 0) @(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_write <= 1'b0;
		@(negedge clk);
	endtask

	// Weights: the two ends, values above one (which act as one) and the
	// range in between.
	function automatic logic [COEF_W-1:0] draw_weight();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return COEF_ONE;
			2:       return COEF_W'($urandom_range(32'h10001, 32'h1FFFF));
			default: return COEF_W'($urandom_range(0, 32'h10000));
		endcase
	endfunction

	// Powers spread over the whole exponent range, with zero and full scale.
	function automatic logic [POWER_W-1:0] draw_power();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			2, 3:    return $urandom >> $urandom_range(0, 31);
			default: return $urandom;
		endcase
	endfunction

	task automatic randomize_config();
		logic [15:0] floor_mag;
		write_reg(REG_AVERAGE_COEF, draw_weight());
		write_reg(REG_ATTACK_COEF, draw_weight());
		write_reg(REG_RELEASE_COEF, draw_weight());
		// Peak hold is on more often than not, since that path has more to it.
		write_reg(REG_PEAK_HOLD_ON, CFG_DATA_W'($urandom_range(0, 3) != 0));
		case ($urandom_range(0, 3))
			0:       write_reg(REG_PEAK_DECAY_STEP, '0);
			1:       write_reg(REG_PEAK_DECAY_STEP, CFG_DATA_W'($urandom_range(0, 65535)));
			default: write_reg(REG_PEAK_DECAY_STEP, CFG_DATA_W'($urandom_range(0, 2000)));
		endcase
		floor_mag = 16'($urandom_range(0, 32768));
		write_reg(REG_DB_FLOOR, CFG_DATA_W'(16'(-floor_mag)));
		case ($urandom_range(0, 3))
			0:       write_reg(REG_NORM_GAIN, CFG_DATA_W'($urandom_range(0, 65535)));
			1:       write_reg(REG_NORM_GAIN, CFG_DATA_W'(16'hFFFF));
			default: write_reg(REG_NORM_GAIN, CFG_DATA_W'($urandom_range(100, 3000)));
		endcase
		if ($urandom_range(0, 3) == 0) begin
			write_reg(REG_SPARE, CFG_DATA_W'($urandom));
		end
	endtask

	initial begin
		logic [BAND_W-1:0] sweep_band;
		logic [BAND_W-1:0] last_band;
		logic [BAND_W-1:0] b;

		arst_n             = 1'b0;
		cfg_write          = 1'b0;
		cfg_index          = '0;
		cfg_data           = '0;
		band_ch.valid      = 1'b0;
		band_ch.band_index = '0;
		band_ch.band_power = '0;
		tx_steady          = 1'b0;
		rx_steady          = 1'b0;
		want_long_hold     = 1'b0;
		sweep_band         = '0;
		last_band          = '0;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, registers at their reset values: silence (zero
		// power counts as the smallest step), full scale, single bits at
		// both ends of the word, the lowest and highest band, and the same
		// band back to back so that the block has to wait for write-back.
		send_band(8'd0, 32'h0000_0000);
		send_band(8'd255, 32'hFFFF_FFFF);
		send_band(8'd1, 32'h0000_0001);
		send_band(8'd2, 32'h8000_0000);
		send_band(8'd3, 32'h0000_FFFF);
		send_band(8'd3, 32'h7FFF_FFFF);
		send_band(8'd3, 32'h0000_0000);
		send_band(8'd128, 32'h5555_AAAA);
		drain();

		// Extremes: averaging frozen, attack weight above one (acts as one),
		// release frozen, peak hold with the largest decay, the lowest
		// floor and the largest gain. The spare index must change nothing.
		write_reg(REG_AVERAGE_COEF, '0);
		write_reg(REG_ATTACK_COEF, '1);
		write_reg(REG_RELEASE_COEF, '0);
		write_reg(REG_PEAK_HOLD_ON, 17'd1);
		write_reg(REG_PEAK_DECAY_STEP, 17'h0FFFF);
		write_reg(REG_DB_FLOOR, 17'h08000);
		write_reg(REG_NORM_GAIN, 17'h0FFFF);
		write_reg(REG_SPARE, '1);
		send_band(8'd255, 32'h0000_0000);
		send_band(8'd4, 32'hFFFF_FFFF);
		send_band(8'd4, 32'h0000_0010);
		send_band(8'd5, 32'hAAAA_5555);
		send_band(8'd5, 32'h0000_0000);
		drain();

		// Opposite extremes: half-weight averaging, a weight just above one
		// on release, a zero floor (every level maps to zero), zero gain and
		// no decay, so peaks hold where they are.
		write_reg(REG_AVERAGE_COEF, 17'h08000);
		write_reg(REG_ATTACK_COEF, 17'h10000);
		write_reg(REG_RELEASE_COEF, 17'h10001);
		write_reg(REG_PEAK_DECAY_STEP, '0);
		write_reg(REG_DB_FLOOR, '0);
		write_reg(REG_NORM_GAIN, '0);
		send_band(8'd4, 32'hFFFF_FFFF);
		send_band(8'd6, 32'h1234_5678);
		send_band(8'd7, 32'h0000_0000);
		drain();

		// Random part. Most bands come in frame order, each one different,
		// which is how a spectrum frame arrives; the rest are scattered
		// bands, a crowd of low bands and straight repeats, which press on
		// the same-band wait in the pipeline.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			randomize_config();
			tx_steady = ($urandom_range(0, 2) == 0);
			rx_steady = ($urandom_range(0, 2) == 0);
			if (ph == 1) begin
				// The sender keeps offering while the receiver holds off.
				tx_steady      = 1'b1;
				want_long_hold = 1'b1;
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5: begin
						b = sweep_band;
						sweep_band++;
					end
					6, 7:    b = BAND_W'($urandom_range(0, 255));
					8:       b = BAND_W'($urandom_range(0, 3));
					default: b = last_band;
				endcase
				send_band(b, draw_power());
				last_band = b;
				if (ph == 3 && n == PHASE_ITEMS / 2) begin
					// The sender pauses mid-phase until everything is back.
					drain();
				end
			end
			drain();
		end

		if (mismatch_count == 0 && results_owed == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

@@ files.f @@
src/sbb_pkg.sv
src/sbb_in_if.sv
src/sbb_out_if.sv
src/spectrum_band_ballistics.sv
test/sbb_checker.sv
test/tb_spectrum_band_ballistics.sv
